[rtl/dmss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dmss_pkg;

   localparam int STEPS_DEF          = 16;
   localparam int VOICES_DEF         = 8;
   localparam int EVENT_CAPACITY_DEF = 64;

   localparam logic [15:0] SPS_RESET  = 16'd6000;
   localparam logic [6:0]  BASE_RESET = 7'd36;

   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_BLOCK  = 3'd1;
   localparam logic [2:0] FUNC_DRUM   = 3'd2;
   localparam logic [2:0] FUNC_MELODY = 3'd3;
   localparam logic [2:0] FUNC_START  = 3'd4;
   localparam logic [2:0] FUNC_STOP   = 3'd5;
   localparam logic [2:0] FUNC_CLEAR  = 3'd6;

   localparam logic CSR_SPS  = 1'b0;
   localparam logic CSR_BASE = 1'b1;

   localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
   localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
   localparam logic [3:0] CHAN_DRUM     = 4'd9;
   localparam logic [3:0] CHAN_MELODY   = 4'd0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PREV_OFF,
      ST_NOTE_ON,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic drum_we;
      logic mel_we;
      logic rd_en;
   } pat_ctl_type;

endpackage
`default_nettype wire

[rtl/dmss_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dmss_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [2:0]  voice;
   logic [3:0]  step_index;
   logic [6:0]  note;
   logic [6:0]  velocity;
   logic [15:0] block_len;

   modport source (output valid, func, voice, step_index, note, velocity, block_len,
                   input ready);
   modport sink   (input valid, func, voice, step_index, note, velocity, block_len,
                   output ready);
endinterface

interface dmss_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_offset;
   logic [7:0]  status_byte;
   logic [6:0]  note_number;
   logic [6:0]  velocity_out;
   logic        last;

   modport source (output valid, frame_offset, status_byte, note_number, velocity_out,
                   last, input ready);
   modport sink   (input valid, frame_offset, status_byte, note_number, velocity_out,
                   last, output ready);
endinterface
`default_nettype wire

[rtl/dmss_pat_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module dmss_pat_mem #(
   parameter int STEPS  = dmss_pkg::STEPS_DEF,
   parameter int VOICES = dmss_pkg::VOICES_DEF,
   localparam int SW = $clog2(STEPS),
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1,
   localparam int AW = VW + SW
) (
   input  wire                     clock,
   input  dmss_pkg::pat_ctl_type   ctl,
   input  wire  [AW-1:0]           drum_waddr,
   input  wire  [6:0]              drum_wdata,
   input  wire  [AW-1:0]           drum_raddr,
   output logic [6:0]              drum_rdata,
   input  wire  [SW-1:0]           mel_waddr,
   input  wire  [6:0]              mel_wnote,
   input  wire  [6:0]              mel_wvel,
   input  wire  [SW-1:0]           mel_raddr,
   output logic [6:0]              mel_rnote,
   output logic [6:0]              mel_rvel
);
   import dmss_pkg::*;

   logic [6:0]  drum_mem [2**AW];
   logic [13:0] mel_mem  [2**SW];

   always_ff @(posedge clock) begin
      if (ctl.drum_we) begin
         drum_mem[drum_waddr] <= drum_wdata;
      end
      if (ctl.rd_en) begin
         drum_rdata <= drum_mem[drum_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mel_we) begin
         mel_mem[mel_waddr] <= {mel_wnote, mel_wvel};
      end
      if (ctl.rd_en) begin
         {mel_rnote, mel_rvel} <= mel_mem[mel_raddr];
      end
   end

endmodule
`default_nettype wire

[rtl/drum_melody_step_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Step sequencer with VOICES drum tracks and one melody track, STEPS steps long. Requests
// other than a clear or a tick that lands on a step are done while the sequencer stays idle.
// A step tick scans the tracks one at a time through the pattern memory read port: each
// track is read, then evaluated, and each event sent waits in its send state until the
// response slot is free. After reset and after a clear request the pattern memory is swept
// to zero, one entry a cycle, over all 2**(VW+SW) entries (128 at the defaults), and no
// request is taken meanwhile; csr writes are taken at any time.
module drum_melody_step_sequencer #(
   parameter int STEPS          = dmss_pkg::STEPS_DEF,
   parameter int VOICES         = dmss_pkg::VOICES_DEF,
   parameter int EVENT_CAPACITY = dmss_pkg::EVENT_CAPACITY_DEF
) (
   input  wire          clock,
   input  wire          reset,
   dmss_req_if.sink     req_ch,
   dmss_rsp_if.source   rsp_ch,
   input  wire          csr_wr_en,
   input  wire          csr_index,
   input  wire  [15:0]  csr_wdata
);
   import dmss_pkg::*;

   localparam int SW = $clog2(STEPS);
   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int AW = VW + SW;
   localparam int TW = $clog2(VOICES + 1);

   state_type   state_ff, state_in;

   logic [15:0] sps_ff;
   logic [6:0]  base_ff;
   logic        playing_ff, playing_in;
   logic [15:0] tick_cnt_ff, tick_cnt_in;
   logic [SW-1:0] step_ff, step_in;
   logic [6:0]  ev_cnt_ff, ev_cnt_in;
   logic [15:0] blen_ff, blen_in;
   logic [15:0] gate_ff, gate_in;
   logic [TW-1:0] track_ff, track_in;
   logic        pend_ff, pend_in;
   logic [6:0]  cur_note_ff, cur_note_in;
   logic [3:0]  cur_chan_ff, cur_chan_in;
   logic [AW-1:0] sweep_ff, sweep_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_off_ff, rsp_off_in;
   logic [7:0]  rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_note_ff, rsp_note_in;
   logic [6:0]  rsp_vel_ff, rsp_vel_in;
   logic        rsp_last_ff, rsp_last_in;

   pat_ctl_type pat_ctl;
   logic [AW-1:0] drum_waddr;
   logic [6:0]    drum_wdata;
   logic [6:0]    drum_rdata;
   logic [SW-1:0] mel_waddr;
   logic [6:0]    mel_wnote, mel_wvel;
   logic [6:0]    mel_rnote, mel_rvel;

   logic        accept;
   logic        slot_free;
   logic [16:0] cnt_inc;
   logic        step_hit;
   logic        tick_step;
   logic [15:0] half_step;
   logic [15:0] gate_calc;
   logic        is_mel;
   logic [6:0]  ev_vel;
   logic [6:0]  ev_note;
   logic [3:0]  ev_chan;
   logic        fits;
   logic        emit;
   logic        drum_wr_ok;
   logic        mel_wr_ok;

   assign req_ch.ready = state_ff == ST_IDLE;
   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign cnt_inc   = {1'b0, tick_cnt_ff} + 17'd1;
   assign step_hit  = cnt_inc >= {1'b0, sps_ff};
   assign tick_step = accept && (req_ch.func == FUNC_TICK) && playing_ff && step_hit;

   assign half_step = (sps_ff > 16'd1) ? (sps_ff >> 1) : 16'd1;
   assign gate_calc = (half_step >= blen_ff) ?
                      ((blen_ff > 16'd1) ? (blen_ff - 16'd1) : 16'd1) : half_step;

   assign is_mel  = track_ff == TW'(VOICES);
   assign ev_vel  = is_mel ? mel_rvel : drum_rdata;
   assign ev_note = is_mel ? mel_rnote : 7'(base_ff + 7'(track_ff));
   assign ev_chan = is_mel ? CHAN_MELODY : CHAN_DRUM;
   assign fits    = ({1'b0, ev_cnt_ff} + 8'd2) <= 8'(EVENT_CAPACITY);
   assign emit    = (ev_vel != 7'd0) && fits;

   assign drum_wr_ok = (32'(req_ch.voice) < VOICES) && (32'(req_ch.step_index) < STEPS);
   assign mel_wr_ok  = 32'(req_ch.step_index) < STEPS;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_ch.func == FUNC_CLEAR)) begin
               state_in = ST_CLEAR;
            end else if (tick_step) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (emit) begin
               state_in = pend_ff ? ST_PREV_OFF : ST_NOTE_ON;
            end else if (!is_mel) begin
               state_in = ST_READ;
            end else begin
               state_in = pend_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_PREV_OFF: begin
            if (slot_free) begin
               state_in = ST_NOTE_ON;
            end
         end
         ST_NOTE_ON: begin
            if (slot_free) begin
               state_in = is_mel ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      playing_in    = playing_ff;
      tick_cnt_in   = tick_cnt_ff;
      step_in       = step_ff;
      ev_cnt_in     = ev_cnt_ff;
      blen_in       = blen_ff;
      gate_in       = gate_ff;
      track_in      = track_ff;
      pend_in       = pend_ff;
      cur_note_in   = cur_note_ff;
      cur_chan_in   = cur_chan_ff;
      sweep_in      = sweep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_off_in    = rsp_off_ff;
      rsp_status_in = rsp_status_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_last_in   = rsp_last_ff;
      pat_ctl       = '0;
      drum_waddr    = {VW'(req_ch.voice), SW'(req_ch.step_index)};
      drum_wdata    = req_ch.velocity;
      mel_waddr     = SW'(req_ch.step_index);
      mel_wnote     = req_ch.note;
      mel_wvel      = req_ch.velocity;

      unique case (state_ff)
         ST_CLEAR: begin
            pat_ctl.drum_we = 1'b1;
            pat_ctl.mel_we  = 1'b1;
            drum_waddr      = sweep_ff;
            drum_wdata      = 7'd0;
            mel_waddr       = sweep_ff[SW-1:0];
            mel_wnote       = 7'd0;
            mel_wvel        = 7'd0;
            sweep_in        = sweep_ff + AW'(1);
         end
         ST_IDLE: begin
            sweep_in     = '0;
            if (accept) begin
               unique case (req_ch.func)
                  FUNC_TICK: begin
                     if (playing_ff) begin
                        if (step_hit) begin
                           tick_cnt_in = 16'd0;
                           step_in     = (step_ff == SW'(STEPS - 1)) ? '0 : step_ff + SW'(1);
                           gate_in     = gate_calc;
                           track_in    = '0;
                           pend_in     = 1'b0;
                        end else begin
                           tick_cnt_in = cnt_inc[15:0];
                        end
                     end
                  end
                  FUNC_BLOCK: begin
                     ev_cnt_in = 7'd0;
                     blen_in   = req_ch.block_len;
                  end
                  FUNC_DRUM: begin
                     pat_ctl.drum_we = drum_wr_ok;
                  end
                  FUNC_MELODY: begin
                     pat_ctl.mel_we = mel_wr_ok;
                  end
                  FUNC_START: begin
                     playing_in  = 1'b1;
                     step_in     = '0;
                     tick_cnt_in = 16'd0;
                  end
                  FUNC_STOP: begin
                     playing_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            pat_ctl.rd_en = 1'b1;
         end
         ST_EVAL: begin
            if (emit) begin
               ev_cnt_in = ev_cnt_ff + 7'd2;
            end else if (!is_mel) begin
               track_in = track_ff + TW'(1);
            end
         end
         ST_PREV_OFF, ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_off_in    = gate_ff;
               rsp_status_in = MIDI_NOTE_OFF | {4'd0, cur_chan_ff};
               rsp_note_in   = cur_note_ff;
               rsp_vel_in    = 7'd0;
               rsp_last_in   = state_ff == ST_FLUSH;
            end
         end
         ST_NOTE_ON: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_off_in    = 16'd0;
               rsp_status_in = MIDI_NOTE_ON | {4'd0, ev_chan};
               rsp_note_in   = ev_note;
               rsp_vel_in    = ev_vel;
               rsp_last_in   = 1'b0;
               cur_note_in   = ev_note;
               cur_chan_in   = ev_chan;
               pend_in       = 1'b1;
               if (!is_mel) begin
                  track_in = track_ff + TW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sps_ff       <= SPS_RESET;
         base_ff      <= BASE_RESET;
         playing_ff   <= 1'b0;
         tick_cnt_ff  <= 16'd0;
         step_ff      <= '0;
         ev_cnt_ff    <= 7'd0;
         blen_ff      <= 16'd0;
         track_ff     <= '0;
         pend_ff      <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         tick_cnt_ff  <= tick_cnt_in;
         step_ff      <= step_in;
         ev_cnt_ff    <= ev_cnt_in;
         blen_ff      <= blen_in;
         track_ff     <= track_in;
         pend_ff      <= pend_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SPS:  sps_ff  <= csr_wdata;
               CSR_BASE: base_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      gate_ff       <= gate_in;
      cur_note_ff   <= cur_note_in;
      cur_chan_ff   <= cur_chan_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   dmss_pat_mem #(
      .STEPS  (STEPS),
      .VOICES (VOICES)
   ) u_pat_mem (
      .clock      (clock),
      .ctl        (pat_ctl),
      .drum_waddr (drum_waddr),
      .drum_wdata (drum_wdata),
      .drum_raddr ({VW'(track_ff), step_ff}),
      .drum_rdata (drum_rdata),
      .mel_waddr  (mel_waddr),
      .mel_wnote  (mel_wnote),
      .mel_wvel   (mel_wvel),
      .mel_raddr  (step_ff),
      .mel_rnote  (mel_rnote),
      .mel_rvel   (mel_rvel)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_offset = rsp_off_ff;
   assign rsp_ch.status_byte  = rsp_status_ff;
   assign rsp_ch.note_number  = rsp_note_ff;
   assign rsp_ch.velocity_out = rsp_vel_ff;
   assign rsp_ch.last         = rsp_last_ff;

`ifndef ASSERT_OFF
   a_budget: assert property (@(posedge clock) disable iff (reset)
      32'(ev_cnt_ff) <= EVENT_CAPACITY)
      else $error("event budget overrun");

   a_last_is_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last) |-> (rsp_ch.status_byte[7:4] == MIDI_NOTE_OFF[7:4]))
      else $error("last flag on a note-on");

   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) || (state_ff == ST_PREV_OFF)) |-> pend_ff)
      else $error("note-off sent with nothing pending");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !$rose(rsp_ch.valid))
      else $error("response raised during pattern clear");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_drum_melody_step_sequencer.sv]
`timescale 1ns / 1ps
module tb_drum_melody_step_sequencer;
   import dmss_pkg::*;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 200;
   localparam int REPORT_CAP    = 100;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 62;
   localparam int LONG_SPS      = 20;

   typedef struct {
      logic [2:0]  func;
      logic [2:0]  voice;
      logic [3:0]  step_index;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [15:0] block_len;
   } seq_req_type;

   typedef struct {
      logic [15:0] frame_offset;
      logic [7:0]  status_byte;
      logic [6:0]  note_number;
      logic [6:0]  velocity_out;
      logic        last;
   } midi_event_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   dmss_req_if req_ch ();
   dmss_rsp_if rsp_ch ();

   drum_melody_step_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   seq_req_type    seq_pending [$];
   midi_event_type midi_expected [$];
   midi_event_type step_events [$];

   seq_req_type    drv_item;
   seq_req_type    mon_req;
   midi_event_type mon_evt;

   int  mismatch_count = 0;
   int  stall_cycles = 0;
   int  send_gap = 0;
   int  recv_hold = 0;
   bit  idling_on = 1'b1;

   // sequencer state as predicted
   int          cfg_sps = SPS_RESET;
   logic [6:0]  cfg_base = BASE_RESET;
   bit          seq_playing = 1'b0;
   int          seq_ticks = 0;
   int          seq_step = 0;
   int          seq_events = 0;
   int          seq_block_len = 0;
   logic [6:0]  drum_vel [VOICES_DEF][STEPS_DEF];
   logic [6:0]  mel_note [STEPS_DEF];
   logic [6:0]  mel_vel [STEPS_DEF];

   int phase_sps [PHASES]  = '{0, 2, 3, 5, 16};
   int phase_base [PHASES] = '{120, 36, 7, 0, 90};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_pattern();
      foreach (drum_vel[v, s]) drum_vel[v][s] = '0;
      foreach (mel_note[s]) begin
         mel_note[s] = '0;
         mel_vel[s] = '0;
      end
   endfunction

   function automatic void queue_note_pair(logic [6:0] pitch, logic [6:0] vel,
                                           logic [3:0] chan, logic [15:0] gate);
      midi_event_type ev;
      if (seq_events + 2 > EVENT_CAPACITY_DEF) return;
      ev.frame_offset = '0;
      ev.status_byte  = MIDI_NOTE_ON | {4'd0, chan};
      ev.note_number  = pitch;
      ev.velocity_out = vel;
      ev.last         = 1'b0;
      step_events.push_back(ev);
      ev.frame_offset = gate;
      ev.status_byte  = MIDI_NOTE_OFF | {4'd0, chan};
      ev.velocity_out = '0;
      step_events.push_back(ev);
      seq_events += 2;
   endfunction

   function automatic void predict_midi(seq_req_type r);
      int gate;
      int v;
      step_events.delete();
      case (r.func)
         FUNC_TICK: begin
            if (seq_playing) begin
               seq_ticks++;
               if (seq_ticks >= cfg_sps) begin
                  seq_ticks = 0;
                  seq_step = (seq_step + 1) % STEPS_DEF;
                  gate = (cfg_sps > 1) ? cfg_sps / 2 : 1;
                  if (gate >= seq_block_len) gate = (seq_block_len > 1) ? seq_block_len - 1 : 1;
                  for (v = 0; v < VOICES_DEF; v++) begin
                     if (drum_vel[v][seq_step] != 0)
                        queue_note_pair(7'(cfg_base + v), drum_vel[v][seq_step], CHAN_DRUM,
                                        16'(gate));
                  end
                  if (mel_vel[seq_step] != 0)
                     queue_note_pair(mel_note[seq_step], mel_vel[seq_step], CHAN_MELODY,
                                     16'(gate));
               end
            end
         end
         FUNC_BLOCK: begin
            seq_events = 0;
            seq_block_len = r.block_len;
         end
         FUNC_DRUM: drum_vel[r.voice][r.step_index] = r.velocity;
         FUNC_MELODY: begin
            mel_note[r.step_index] = r.note;
            mel_vel[r.step_index] = r.velocity;
         end
         FUNC_START: begin
            seq_playing = 1'b1;
            seq_step = 0;
            seq_ticks = 0;
         end
         FUNC_STOP: seq_playing = 1'b0;
         FUNC_CLEAR: clear_pattern();
         default: ;
      endcase
      if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) midi_expected.push_back(step_events[i]);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < REPORT_CAP) $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_midi(midi_event_type got);
      midi_event_type want;
      if (midi_expected.size() == 0) begin
         report_mismatch($sformatf("unexpected event status %h note %0d",
                                   got.status_byte, got.note_number));
         return;
      end
      want = midi_expected.pop_front();
      if (got.frame_offset !== want.frame_offset)
         report_mismatch($sformatf("frame_offset %0d, want %0d",
                                   got.frame_offset, want.frame_offset));
      if (got.status_byte !== want.status_byte)
         report_mismatch($sformatf("status_byte %h, want %h",
                                   got.status_byte, want.status_byte));
      if (got.note_number !== want.note_number)
         report_mismatch($sformatf("note_number %0d, want %0d",
                                   got.note_number, want.note_number));
      if (got.velocity_out !== want.velocity_out)
         report_mismatch($sformatf("velocity_out %0d, want %0d",
                                   got.velocity_out, want.velocity_out));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %b, want %b", got.last, want.last));
   endtask

   function automatic seq_req_type make_request(logic [2:0] f, int v, int s, int n, int vel,
                                                int blen);
      seq_req_type r;
      r.func       = f;
      r.voice      = 3'(v);
      r.step_index = 4'(s);
      r.note       = 7'(n);
      r.velocity   = 7'(vel);
      r.block_len  = 16'(blen);
      return r;
   endfunction

   function automatic seq_req_type random_request();
      seq_req_type r;
      int roll;
      r = make_request(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
      roll = $urandom_range(0, 99);
      if (roll < 48) begin
         r.func = FUNC_TICK;
      end else if (roll < 70) begin
         r.func = FUNC_DRUM;
         if ($urandom_range(0, 3) == 0) r.velocity = '0;
      end else if (roll < 80) begin
         r.func = FUNC_MELODY;
         if ($urandom_range(0, 3) == 0) r.velocity = '0;
      end else if (roll < 83) begin
         r.func = FUNC_BLOCK;
         if ($urandom_range(0, 1) == 0) r.block_len = 16'($urandom_range(0, 24));
      end else if (roll < 90) begin
         r.func = FUNC_START;
      end else if (roll < 95) begin
         r.func = FUNC_STOP;
      end else if (roll < 97) begin
         r.func = FUNC_CLEAR;
      end else begin
         r.func = FUNC_UNUSED;
      end
      return r;
   endfunction

   task automatic write_reg(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_SPS) cfg_sps = value;
      else cfg_base = value[6:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (seq_pending.size() != 0 || req_ch.valid || midi_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (seq_pending.size() != 0) begin
            drv_item = seq_pending.pop_front();
            req_ch.func       <= drv_item.func;
            req_ch.voice      <= drv_item.voice;
            req_ch.step_index <= drv_item.step_index;
            req_ch.note       <= drv_item.note;
            req_ch.velocity   <= drv_item.velocity;
            req_ch.block_len  <= drv_item.block_len;
            req_ch.valid      <= 1'b1;
            if (idling_on && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 6);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor and response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_hold <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            mon_req.func       = req_ch.func;
            mon_req.voice      = req_ch.voice;
            mon_req.step_index = req_ch.step_index;
            mon_req.note       = req_ch.note;
            mon_req.velocity   = req_ch.velocity;
            mon_req.block_len  = req_ch.block_len;
            predict_midi(mon_req);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            mon_evt.frame_offset = rsp_ch.frame_offset;
            mon_evt.status_byte  = rsp_ch.status_byte;
            mon_evt.note_number  = rsp_ch.note_number;
            mon_evt.velocity_out = rsp_ch.velocity_out;
            mon_evt.last         = rsp_ch.last;
            check_midi(mon_evt);
         end
         if (recv_hold != 0) begin
            recv_hold <= recv_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            recv_hold <= $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_SPS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_TICK;
      req_ch.voice = '0;
      req_ch.step_index = '0;
      req_ch.note = '0;
      req_ch.velocity = '0;
      req_ch.block_len = '0;
      rsp_ch.ready = 1'b0;
      clear_pattern();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: one step per tick, gate of one
      write_reg(CSR_SPS, 16'd1);
      write_reg(CSR_BASE, 16'd0);
      seq_pending.push_back(make_request(FUNC_BLOCK, 0, 0, 0, 0, 100));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_DRUM, 0, 1, 0, 127, 0));
      seq_pending.push_back(make_request(FUNC_DRUM, 7, 1, 0, 1, 0));
      seq_pending.push_back(make_request(FUNC_MELODY, 0, 1, 0, 127, 0));
      seq_pending.push_back(make_request(FUNC_MELODY, 0, 2, 127, 5, 0));
      seq_pending.push_back(make_request(FUNC_DRUM, 3, 2, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_DRUM, 7, 0, 0, 127, 0));
      seq_pending.push_back(make_request(FUNC_UNUSED, 7, 15, 127, 127, 65535));
      seq_pending.push_back(make_request(FUNC_START, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_STOP, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_BLOCK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_START, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_BLOCK, 0, 0, 0, 0, 65535));
      seq_pending.push_back(make_request(FUNC_DRUM, 4, 15, 0, 64, 0));
      seq_pending.push_back(make_request(FUNC_CLEAR, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      seq_pending.push_back(make_request(FUNC_STOP, 0, 0, 0, 0, 0));
      wait_idle();

      // random phases: load a pattern, open a block, play, then mixed traffic
      for (int p = 0; p < PHASES; p++) begin
         idling_on = ($urandom_range(0, 3) != 0);
         write_reg(CSR_SPS, 16'(phase_sps[p]));
         write_reg(CSR_BASE, 16'(phase_base[p]));
         repeat (16) begin
            seq_pending.push_back(make_request(($urandom_range(0, 3) == 0) ? FUNC_MELODY
                                               : FUNC_DRUM, $urandom, $urandom, $urandom,
                                               $urandom_range(1, 127), $urandom));
         end
         seq_pending.push_back(make_request(FUNC_BLOCK, 0, 0, 0, 0, $urandom_range(0, 40)));
         seq_pending.push_back(make_request(FUNC_START, 0, 0, 0, 0, 0));
         repeat (PHASE_ITEMS - 18) seq_pending.push_back(random_request());
         wait_idle();
      end

      // longer step, one full step, no idling
      idling_on = 1'b0;
      write_reg(CSR_SPS, 16'(LONG_SPS));
      write_reg(CSR_BASE, 16'd64);
      seq_pending.push_back(make_request(FUNC_BLOCK, 0, 0, 0, 0, 65535));
      seq_pending.push_back(make_request(FUNC_DRUM, 5, 1, 0, 99, 0));
      seq_pending.push_back(make_request(FUNC_MELODY, 0, 1, 3, 50, 0));
      seq_pending.push_back(make_request(FUNC_START, 0, 0, 0, 0, 0));
      repeat (LONG_SPS) seq_pending.push_back(make_request(FUNC_TICK, 0, 0, 0, 0, 0));
      wait_idle();

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
